/* rtl/weighted_round_robin_select_core_macros.svh */
// assertion macros for the weighted round-robin selector
// used by weighted_round_robin_select_core; expects clk and rst_n in scope
`ifndef WEIGHTED_ROUND_ROBIN_SELECT_CORE_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_SELECT_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define WRRS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrrs same-cycle check failed");

// next-cycle implication, off during reset
`define WRRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrrs next-cycle check failed");

`endif

/* rtl/wrrs_pkg.sv */
// shared types and constants of the weighted round-robin selector
// no dependencies
package wrrs_pkg;

  localparam int MAX_PROVIDERS_DEF = 16;
  localparam int WEIGHT_W          = 32;
  localparam int PCOUNT_W          = 5;
  localparam int SLOT_W            = 4;
  localparam int IDX_OUT_W         = 4;
  localparam int TURN_W            = 64;
  localparam int TOTAL_W           = WEIGHT_W + PCOUNT_W;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = PCOUNT_W;

  localparam logic OP_SELECT = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WEIGHTED_MODE  = 1'b0,
    REG_PROVIDER_COUNT = 1'b1
  } wrrs_cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_DIV_GO,
    S_DIV_WAIT,
    S_WALK,
    S_RESULT
  } wrrs_state_t;

endpackage

/* rtl/wrrs_weight_mem.sv */
// weight table: synchronous single-write, single-read memory with a registered read
// per-entry valid bits make unwritten entries read as zero after reset; uses wrrs_pkg
module wrrs_weight_mem #(
  parameter int DEPTH  = wrrs_pkg::MAX_PROVIDERS_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [wrrs_pkg::WEIGHT_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [wrrs_pkg::WEIGHT_W-1:0] rd_data
);

  logic [wrrs_pkg::WEIGHT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              vld_r;
  logic [wrrs_pkg::WEIGHT_W-1:0] rd_data_r;
  logic                          rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  // never-written entries read as the reset weight of zero through their cleared valid bits
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* rtl/wrrs_mod_unit.sv */
// bit-serial restoring remainder unit: 64-bit dividend modulo a nonzero divisor
// one quotient bit per cycle; uses wrrs_pkg
module wrrs_mod_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [wrrs_pkg::TURN_W-1:0]  dividend,
  input  logic [wrrs_pkg::TOTAL_W-1:0] divisor,
  output logic                         done,
  output logic [wrrs_pkg::TOTAL_W-1:0] rem
);

  localparam int CNT_W = $clog2(wrrs_pkg::TURN_W);

  logic                         busy_r;
  logic                         done_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [wrrs_pkg::TURN_W-1:0]  dvd_r;
  logic [wrrs_pkg::TOTAL_W-1:0] dsr_r;
  logic [wrrs_pkg::TOTAL_W-1:0] rem_r;
  logic [wrrs_pkg::TOTAL_W:0]   trial;
  logic [wrrs_pkg::TOTAL_W:0]   diff;
  logic                         fits;

  always_comb begin
    trial = {rem_r, dvd_r[wrrs_pkg::TURN_W-1]};
    diff  = trial - {1'b0, dsr_r};
    fits  = trial >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(wrrs_pkg::TURN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[wrrs_pkg::TURN_W-2:0], 1'b0};
      rem_r <= fits ? diff[wrrs_pkg::TOTAL_W-1:0] : trial[wrrs_pkg::TOTAL_W-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/weighted_round_robin_select_core.sv */
// weighted round-robin provider selector, top level; uses wrrs_pkg, wrrs_weight_mem,
// wrrs_mod_unit and the assertion macros header
// in_* channel: op 0 selects a provider, op 1 writes weight_value into weight_slot
// out_* channel: one transaction per select (found, provider_index), none per weight write
// cfg_* channel: index 0 weighted_mode, index 1 provider_count; always ready
// a weight write does not leave idle, so the block stays ready for the next transaction
// a select with an empty pool goes straight to the result state and gives found 0
// plain select: div_go, then div_wait on the 64-step bit-serial remainder unit, then result
// weighted select: weight sum over the n providers in use, then the remainder, then a prefix
//   walk over up to n entries, n the provider count; a zero weight sum skips the walk
// the weight sum and the walk stream the weight table through its single read port
// one select is in flight at a time; new input is taken only when the engine is idle
// the finished result sits in an output register, so the next transaction is accepted
// while it waits; a stalled receiver holds the engine only once a second result is ready
// reset clears the turn counter, both config registers and the weight table valid bits,
// so every weight reads as zero until written; no clearing pass is needed
`include "weighted_round_robin_select_core_macros.svh"

module weighted_round_robin_select_core #(
  parameter int MAX_PROVIDERS = wrrs_pkg::MAX_PROVIDERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_op,
  input  logic [wrrs_pkg::SLOT_W-1:0]      in_weight_slot,
  input  logic [wrrs_pkg::WEIGHT_W-1:0]    in_weight_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_found,
  output logic [wrrs_pkg::IDX_OUT_W-1:0]   out_provider_index,
  // configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wrrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wrrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W   = (MAX_PROVIDERS > 1) ? $clog2(MAX_PROVIDERS) : 1;
  localparam int PC_W    = wrrs_pkg::PCOUNT_W;
  localparam int TOT_W   = wrrs_pkg::TOTAL_W;

  wrrs_pkg::wrrs_state_t state_r, state_nxt;

  // config registers
  logic                      wmode_r;
  logic [PC_W-1:0]           pcount_r;

  // engine state
  logic [wrrs_pkg::TURN_W-1:0] turn_r;
  logic [PC_W-1:0]           rd_k_r;      // next table entry to read
  logic [PC_W-1:0]           rsp_k_r;     // entry whose data arrives this cycle
  logic                      rsp_vld_r;
  logic [TOT_W-1:0]          total_r;
  logic [TOT_W-1:0]          slot_r;
  logic                      res_found_r;
  logic [wrrs_pkg::IDX_OUT_W-1:0] res_idx_r;

  // output register
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [wrrs_pkg::IDX_OUT_W-1:0] out_idx_r;

  // combinational
  logic [PC_W-1:0]           n_eff;
  logic                      use_w;
  logic [TOT_W-1:0]          divisor;
  logic                      rd_more;
  logic                      hit;
  logic                      in_acc;
  logic                      sel_acc;
  logic                      wr_acc;
  logic                      mem_wr_en;
  logic                      mem_rd_en;
  logic [IDX_W-1:0]          mem_rd_addr;
  logic [wrrs_pkg::WEIGHT_W-1:0] mem_rd_data;
  logic                      mod_start;
  logic                      mod_done;
  logic [TOT_W-1:0]          mod_rem;
  logic                      res_load;

  // provider count saturates at the table depth
  always_comb begin
    n_eff = (32'(pcount_r) > 32'(MAX_PROVIDERS)) ? PC_W'(MAX_PROVIDERS) : pcount_r;
  end

  // weighted only when the weights in use sum to something; total is zeroed per select
  assign use_w   = wmode_r && (total_r != '0);
  assign divisor = use_w ? total_r : TOT_W'(n_eff);
  assign rd_more = rd_k_r < n_eff;
  assign hit     = rsp_vld_r && (slot_r < TOT_W'(mem_rd_data));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wrrs_pkg::S_IDLE: begin
        if (in_valid && in_op == wrrs_pkg::OP_SELECT) begin
          if (n_eff == '0) begin
            state_nxt = wrrs_pkg::S_RESULT;
          end else if (wmode_r) begin
            state_nxt = wrrs_pkg::S_SUM;
          end else begin
            state_nxt = wrrs_pkg::S_DIV_GO;
          end
        end
      end
      wrrs_pkg::S_SUM: begin
        if (!rd_more && !rsp_vld_r) begin
          state_nxt = wrrs_pkg::S_DIV_GO;
        end
      end
      wrrs_pkg::S_DIV_GO: begin
        state_nxt = wrrs_pkg::S_DIV_WAIT;
      end
      wrrs_pkg::S_DIV_WAIT: begin
        if (mod_done) begin
          state_nxt = use_w ? wrrs_pkg::S_WALK : wrrs_pkg::S_RESULT;
        end
      end
      wrrs_pkg::S_WALK: begin
        if (hit) begin
          state_nxt = wrrs_pkg::S_RESULT;
        end
      end
      wrrs_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wrrs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wrrs_pkg::S_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    mem_rd_en   = 1'b0;
    mod_start   = 1'b0;
    res_load    = 1'b0;
    mem_rd_addr = IDX_W'(rd_k_r);
    case (state_r)
      wrrs_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      wrrs_pkg::S_SUM, wrrs_pkg::S_WALK: begin
        // stream reads one entry per cycle; reads past a walk hit are harmless
        mem_rd_en = rd_more;
      end
      wrrs_pkg::S_DIV_GO: begin
        mod_start = 1'b1;
      end
      wrrs_pkg::S_RESULT: begin
        res_load = !out_valid_r || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_acc    = in_valid && in_ready;
  assign sel_acc   = in_acc && (in_op == wrrs_pkg::OP_SELECT);
  assign wr_acc    = in_acc && (in_op == wrrs_pkg::OP_WRITE);
  // writes only happen while idle and reads only while busy, so the two never overlap
  assign mem_wr_en = wr_acc && (32'(in_weight_slot) < 32'(MAX_PROVIDERS));

  assign cfg_ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wrrs_pkg::S_IDLE;
      wmode_r     <= 1'b0;
      pcount_r    <= '0;
      turn_r      <= '0;
      rsp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wrrs_pkg::REG_WEIGHTED_MODE:  wmode_r  <= cfg_wdata[0];
          wrrs_pkg::REG_PROVIDER_COUNT: pcount_r <= cfg_wdata;
          default: begin
            wmode_r <= wmode_r;
          end
        endcase
      end
      // response tracking for the streamed table reads
      if (state_r == wrrs_pkg::S_SUM || state_r == wrrs_pkg::S_WALK) begin
        rsp_vld_r <= mem_rd_en;
      end else begin
        rsp_vld_r <= 1'b0;
      end
      // turn advances once per select that found a provider
      if (res_load && res_found_r) begin
        turn_r <= turn_r + 1'b1;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      wrrs_pkg::S_IDLE: begin
        if (sel_acc) begin
          rd_k_r      <= '0;
          total_r     <= '0;
          res_found_r <= (n_eff != '0);
          res_idx_r   <= '0;
        end
      end
      wrrs_pkg::S_SUM: begin
        if (mem_rd_en) begin
          rd_k_r <= rd_k_r + 1'b1;
        end
        rsp_k_r <= rd_k_r;
        if (rsp_vld_r) begin
          total_r <= total_r + TOT_W'(mem_rd_data);
        end
      end
      wrrs_pkg::S_DIV_WAIT: begin
        if (mod_done) begin
          slot_r    <= mod_rem;
          rd_k_r    <= '0;
          res_idx_r <= mod_rem[wrrs_pkg::IDX_OUT_W-1:0];
        end
      end
      wrrs_pkg::S_WALK: begin
        if (mem_rd_en) begin
          rd_k_r <= rd_k_r + 1'b1;
        end
        rsp_k_r <= rd_k_r;
        if (hit) begin
          res_idx_r <= rsp_k_r[wrrs_pkg::IDX_OUT_W-1:0];
        end else if (rsp_vld_r) begin
          slot_r <= slot_r - TOT_W'(mem_rd_data);
        end
      end
      default: begin
        rsp_k_r <= rsp_k_r;
      end
    endcase
    if (res_load) begin
      out_found_r <= res_found_r;
      out_idx_r   <= res_idx_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_provider_index = out_idx_r;

  wrrs_weight_mem #(
    .DEPTH  (MAX_PROVIDERS),
    .ADDR_W (IDX_W)
  ) u_weight_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (IDX_W'(in_weight_slot)),
    .wr_data (in_weight_value),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  wrrs_mod_unit u_mod_unit (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (turn_r),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // remainder unit only finishes while the engine waits for it
  `WRRS_ASSERT_IMPLY(a_mod_done_in_wait, mod_done, state_r == wrrs_pkg::S_DIV_WAIT)
  // the walk never runs past the weight total
  `WRRS_ASSERT_IMPLY(a_walk_slot_bound, state_r == wrrs_pkg::S_WALK, slot_r < total_r)
  // an empty-pool result leaves the turn counter alone
  `WRRS_ASSERT_NEXT(a_turn_hold_empty, res_load && !res_found_r, $stable(turn_r))
  // a found result always advances the turn counter by one
  `WRRS_ASSERT_NEXT(a_turn_step, res_load && res_found_r, turn_r == $past(turn_r) + 1'b1)

endmodule

/* dv/testbench.sv */
// self-checking testbench for weighted_round_robin_select_core
// depends on wrrs_pkg and the core rtl; holds its own selection predictor and checks each result
// directed selects and weight writes first, then random config phases with random traffic
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          op;
    logic [wrrs_pkg::SLOT_W-1:0]   slot;
    logic [wrrs_pkg::WEIGHT_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic                           found;
    logic [wrrs_pkg::IDX_OUT_W-1:0] index;
  } pick_t;

  // clock, reset and dut ports; the driven dut inputs are known from time zero
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_op = wrrs_pkg::OP_SELECT;
  logic [wrrs_pkg::SLOT_W-1:0]     in_weight_slot = '0;
  logic [wrrs_pkg::WEIGHT_W-1:0]   in_weight_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_found;
  logic [wrrs_pkg::IDX_OUT_W-1:0]  out_provider_index;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  wrrs_pkg::wrrs_cfg_reg_t         cfg_index = wrrs_pkg::REG_WEIGHTED_MODE;
  logic [wrrs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state: the block's turn counter, weight table and config copy
  logic [wrrs_pkg::TURN_W-1:0]     turn_count = '0;
  logic [wrrs_pkg::WEIGHT_W-1:0]   weights [wrrs_pkg::MAX_PROVIDERS_DEF] = '{default: '0};
  logic                            weighted_on = 1'b0;
  logic [wrrs_pkg::PCOUNT_W-1:0]   pool_count = '0;

  request_t request_queue [$];   // requests waiting for the driver
  pick_t    expected_picks [$];  // predicted selections, oldest first
  request_t cur_req;             // request currently held on the in_ port
  int       queued = 0;
  int       mismatches = 0;

  // sender burst/gap state and receiver stall state
  int burst_left = 0;
  int gap_left = 0;
  int ready_run = 0;
  int ready_hold = 0;

  weighted_round_robin_select_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_weight_slot     (in_weight_slot),
    .in_weight_value    (in_weight_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_found          (out_found),
    .out_provider_index (out_provider_index),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // selection predictor: consumes one turn when the pool is non-empty
  function automatic pick_t predict_pick();
    pick_t                         r;
    logic [wrrs_pkg::PCOUNT_W-1:0] n;
    logic [wrrs_pkg::TOTAL_W-1:0]  total;
    logic [wrrs_pkg::TURN_W-1:0]   turn;
    logic [wrrs_pkg::TURN_W-1:0]   pos;
    logic                          hit;
    r = '0;
    n = (pool_count > wrrs_pkg::MAX_PROVIDERS_DEF) ?
        wrrs_pkg::PCOUNT_W'(wrrs_pkg::MAX_PROVIDERS_DEF) : pool_count;
    // empty pool: not found, counter left alone
    if (n == 0) return r;
    turn = turn_count;
    turn_count = turn_count + 1'b1;
    r.found = 1'b1;
    r.index = wrrs_pkg::IDX_OUT_W'(turn % n);
    if (weighted_on) begin
      total = '0;
      for (int k = 0; k < n; k++) total += weights[k];
      // all weights in use zero: plain round robin result stands
      if (total != 0) begin
        pos = turn % total;
        hit = 1'b0;
        for (int k = 0; k < n; k++) begin
          if (!hit) begin
            if (pos < weights[k]) begin
              r.index = wrrs_pkg::IDX_OUT_W'(k);
              hit = 1'b1;
            end else begin
              pos -= weights[k];
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [wrrs_pkg::WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  task automatic push_write(input int slot, input logic [wrrs_pkg::WEIGHT_W-1:0] value);
    request_t r;
    r.op = wrrs_pkg::OP_WRITE;
    r.slot = wrrs_pkg::SLOT_W'(slot);
    r.value = value;
    request_queue = {request_queue, r};
    queued++;
  endtask

  // slot and value are don't-care on a select, so they carry noise
  task automatic push_select();
    request_t r;
    r.op = wrrs_pkg::OP_SELECT;
    r.slot = wrrs_pkg::SLOT_W'($urandom);
    r.value = $urandom;
    request_queue = {request_queue, r};
    queued++;
  endtask

  // wait until every request is taken and every predicted result has come back
  task automatic wait_idle(input int settle);
    while (request_queue.size() != 0 || in_valid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // both registers back to back, valid held high across the two transactions
  task automatic write_config(input logic [wrrs_pkg::CFG_DATA_W-1:0] mode_data,
                              input logic [wrrs_pkg::CFG_DATA_W-1:0] count_data);
    cfg_valid <= 1'b1;
    cfg_index <= wrrs_pkg::REG_WEIGHTED_MODE;
    cfg_wdata <= mode_data;
    do @(posedge clk); while (!cfg_ready);
    weighted_on = mode_data[0];
    cfg_index <= wrrs_pkg::REG_PROVIDER_COUNT;
    cfg_wdata <= count_data;
    do @(posedge clk); while (!cfg_ready);
    pool_count = count_data;
    cfg_valid <= 1'b0;
  endtask

  // request driver: bursts of random length, random gaps, payload held until taken
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     drive;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drive = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        // accepted transaction: update the predictor
        if (cur_req.op == wrrs_pkg::OP_WRITE) begin
          weights[cur_req.slot] = cur_req.value;
        end else begin
          expected_picks = {expected_picks, predict_pick()};
        end
      end
      if (!drive) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          nxt = request_queue.pop_front();
          cur_req = nxt;
          drive = 1'b1;
          in_op <= nxt.op;
          in_weight_slot <= nxt.slot;
          in_weight_value <= nxt.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= drive;
    end
  end

  // receiver: long ready stretches mixed with short bursts and stalls
  always @(posedge clk) begin : drive_ready
    if (ready_run > 0) begin
      out_ready <= 1'b1;
      ready_run--;
    end else if (ready_hold > 0) begin
      out_ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ready <= 1'b0;
      ready_run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      ready_hold = $urandom_range(0, 15);
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    pick_t exp_pick;
    if (rst_n && out_valid && out_ready) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b index=%0d",
                                  out_found, out_provider_index));
      end else begin
        exp_pick = expected_picks.pop_front();
        if (out_found !== exp_pick.found)
          report_mismatch($sformatf("found %0b, predicted %0b", out_found, exp_pick.found));
        if (out_provider_index !== exp_pick.index)
          report_mismatch($sformatf("provider_index %0d, predicted %0d",
                                    out_provider_index, exp_pick.index));
      end
    end
  end

  // run limit, several times the slowest legal run
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int                              phase;
    int                              items;
    int                              active;
    logic [wrrs_pkg::CFG_DATA_W-1:0] mode_data;
    logic [wrrs_pkg::CFG_DATA_W-1:0] count_data;
    phase = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: empty pool, selects give not found
    push_select();
    push_select();
    push_write(15, 32'hFFFF_FFFF);
    push_write(3, 32'h0);
    push_select();
    wait_idle(8);

    // weighted, three providers, all weights zero: falls back to plain; then weights on slots 1 and 2
    write_config(5'd1, 5'd3);
    repeat (3) push_select();
    push_write(1, 32'd1);
    push_write(2, 32'd2);
    repeat (3) push_select();
    wait_idle(8);

    // count above the table size saturates; extreme weight on slot 15 and slot 0
    write_config(5'd1, 5'd31);
    repeat (2) push_select();
    push_write(0, 32'hFFFF_FFFF);
    push_select();
    wait_idle(8);

    // mode data with bit 0 clear is plain mode; full pool
    write_config(5'b11110, 5'd16);
    repeat (3) push_select();
    push_write(7, 32'd5);
    push_select();
    wait_idle(8);

    // weighted with a single provider
    write_config(5'd1, 5'd1);
    repeat (2) push_select();
    wait_idle(8);

    // random phases: new config, optional table setup, then mixed traffic
    while (queued < 1300) begin
      mode_data = wrrs_pkg::CFG_DATA_W'($urandom_range(0, 31));
      case ($urandom_range(0, 9))
        0: count_data = 5'd0;
        1: count_data = 5'd16;
        2: count_data = wrrs_pkg::CFG_DATA_W'($urandom_range(17, 31));
        default: count_data = wrrs_pkg::CFG_DATA_W'($urandom_range(1, 16));
      endcase
      write_config(mode_data, count_data);
      active = (count_data > wrrs_pkg::MAX_PROVIDERS_DEF) ? wrrs_pkg::MAX_PROVIDERS_DEF
                                                          : int'(count_data);
      case ($urandom_range(0, 4))
        0: for (int k = 0; k < wrrs_pkg::MAX_PROVIDERS_DEF; k++) push_write(k, '0);
        1, 2: for (int k = 0; k < active; k++) push_write(k, $urandom_range(1, 6));
        default: ;
      endcase
      items = $urandom_range(30, 110);
      for (int k = 0; k < items; k++) begin
        // hold the sender until the pipeline has fully drained
        if (k == items / 2 && (phase == 0 || $urandom_range(0, 2) == 0)) wait_idle(0);
        if ($urandom_range(0, 9) < 3) push_write($urandom_range(0, 15), rand_weight());
        else push_select();
      end
      wait_idle(8);
      phase++;
    end

    // trailing window catches stray results
    wait_idle(150);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/wrrs_pkg.sv
rtl/wrrs_weight_mem.sv
rtl/wrrs_mod_unit.sv
rtl/weighted_round_robin_select_core.sv
dv/testbench.sv
